### rtl/core/tli_pkg.sv
// Package for the table linear interpolator: payload structs, status codes,
// controller states and datapath command/status structs. No dependencies.
`default_nettype none
package tli_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 5;

  typedef logic [2:0] status_t;
  localparam status_t ST_INTERP    = 3'd0;
  localparam status_t ST_CLAMP_LO  = 3'd1;
  localparam status_t ST_CLAMP_HI  = 3'd2;
  localparam status_t ST_ZERO_SEG  = 3'd3;
  localparam status_t ST_WRITE     = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_x;
    logic signed [DATA_W-1:0] entry_y;
    logic signed [DATA_W-1:0] query_x;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] slope;
    logic [IDX_W-1:0]         segment;
    status_t                  status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_LO, S_CHK_LO, S_CHK_HI, S_SEARCH, S_SRCH_CHK,
    S_RD_SEG, S_PREP, S_DIV_V, S_DIV_S, S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch request, init search bounds
    logic write_mem;  // store one breakpoint
    logic rd_first;   // read entry 0
    logic rd_last;    // read last entry
    logic rd_mid;     // read search midpoint
    logic step;       // update search bounds from read
    logic rd_lo;      // read segment lower entry
    logic rd_hi;      // read segment upper entry
    logic prep;       // form deltas
    logic div_start;  // launch divider
    logic div_sel;    // 0 value quotient, 1 slope quotient
    logic finish;     // form result, pulse strobe
    status_t fin_status;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic le_first;
    logic ge_last;
    logic search_done;
    logic dx_zero;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/core/table_linear_interpolator_unit.sv
// Top level of the table linear interpolator: controller plus datapath.
// Depends on tli_pkg, tli_control, tli_datapath.
//
// Usage: drive req and raise start while busy is low; the request is taken
// at that edge. A write request stores one breakpoint (x, y) in Q16.16 and
// strobes a write result. An evaluate request checks the first breakpoint,
// then the last (ending there when clamped low or high), then runs a binary
// search with one table read per step (up to log2(MAX_POINTS) steps), then
// two serial divisions on the shared divider over 96 quotient bits each, or
// none when the segment has zero width. A new request can be taken in the
// cycle the result is strobed. The result is held on res with res_valid
// high for exactly one cycle, which cannot be held off. Table size is
// written through cfg_valid/cfg_ready while the unit is idle; cfg_ready is
// high whenever busy is low. Synchronous reset returns the controller to
// idle and table size to 2; breakpoint contents are undefined until
// written.
`default_nettype none
module table_linear_interpolator_unit
  import tli_pkg::*;
#(
  parameter int MAX_POINTS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t req,
  output result_t       res,
  output logic          res_valid,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [5:0] cfg_data
);
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [5:0] table_size;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) table_size <= 6'd2;
    else if (cfg_valid && cfg_ready) table_size <= cfg_data;
  end

  tli_control u_ctl (
    .clk (clk), .rst (rst), .start (start), .op (req.op),
    .stat (stat), .cmd (cmd), .busy (busy)
  );

  tli_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk (clk), .rst (rst), .req (req), .table_size (table_size),
    .cmd (cmd), .stat (stat), .result (res), .strobe (res_valid)
  );
endmodule
`default_nettype wire

### rtl/core/tli_divider.sv
// Serial restoring divider: floor(n/d) on magnitudes, one quotient bit per
// cycle over a 96-bit dividend n, saturating at 2^40. Depends on nothing.
`default_nettype none
module tli_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [95:0] dividend,
  input  wire logic [32:0] divisor,
  output logic             done,
  output logic [40:0]      quotient
);
  localparam int N = 96;
  localparam logic [40:0] QCAP = 41'h100_0000_0000;

  logic [95:0] num;
  logic [33:0] rem;
  logic [32:0] den;
  logic [6:0]  count;
  logic        running;
  logic [33:0] trial;
  logic [40:0] q_shift;

  assign trial = {rem[32:0], num[95]};
  assign q_shift = {quotient[39:0], (trial >= {1'b0, den})};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= 7'(N);
      end else if (running) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // one shift-subtract step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (running) begin
      num <= {num[94:0], 1'b0};
      if (trial >= {1'b0, den}) rem <= trial - {1'b0, den};
      else rem <= trial;
      if (quotient[40] || q_shift > QCAP) quotient <= QCAP;
      else quotient <= q_shift;
    end
  end
endmodule
`default_nettype wire

### rtl/core/tli_datapath.sv
// Datapath: breakpoint memories, search bounds, deltas, shared divider and
// result assembly. Depends on tli_pkg and tli_divider.
`default_nettype none
module tli_datapath
  import tli_pkg::*;
#(
  parameter int MAX_POINTS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire request_t req,
  input  wire logic [5:0] table_size,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output result_t       result,
  output logic          strobe
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];

  request_t           r;
  logic [AW:0]        n_use;
  logic [AW:0]        lo, hi, mid;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_x, rd_y;
  logic signed [31:0] xlo, ylo, xhi, yhi;
  logic signed [32:0] dx, dy, ddx;
  logic signed [32:0] num_v;
  logic [32:0]        mag_num, mag_dy;
  logic               neg_v, neg_s;
  logic               div_start_q;
  logic [95:0]        dividend;
  logic [40:0]        quot;
  logic               div_done;
  logic signed [42:0] q_signed;
  logic signed [31:0] val_q, slope_q;
  logic signed [43:0] vsum;

  // table size saturated to 2..MAX_POINTS
  always_comb begin
    if (table_size < 6'd2) n_use = (AW+1)'(2);
    else if (int'(table_size) > MAX_POINTS) n_use = (AW+1)'(MAX_POINTS);
    else n_use = (AW+1)'(table_size);
  end

  assign mid = (lo + hi) >> 1;

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_last) rd_addr = AW'(n_use - (AW+1)'(1));
    else if (cmd.rd_mid) rd_addr = mid[AW-1:0];
    else if (cmd.rd_lo) rd_addr = lo[AW-1:0];
    else if (cmd.rd_hi) rd_addr = hi[AW-1:0];
    else if (cmd.rd_first) rd_addr = '0;
  end

  // breakpoint memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.write_mem && 32'(r.entry_index) < 32'(MAX_POINTS)) begin
      mem_x[AW'(r.entry_index)] <= r.entry_x;
      mem_y[AW'(r.entry_index)] <= r.entry_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  assign stat.le_first    = r.query_x <= rd_x;
  assign stat.ge_last     = r.query_x >= rd_x;
  assign stat.search_done = (hi - lo) <= (AW+1)'(1);
  assign stat.dx_zero     = (dx == '0);
  assign stat.div_done    = div_done;

  // search bounds and segment operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r  <= req;
      lo <= '0;
      hi <= n_use - (AW+1)'(1);
    end
    if (cmd.step) begin
      if (r.query_x < rd_x) hi <= mid;
      else lo <= mid;
    end
    if (cmd.rd_hi) begin  // data from lo read is in rd_x now
      xlo <= rd_x;
      ylo <= rd_y;
    end
    if (cmd.prep) begin
      xhi <= rd_x;
      yhi <= rd_y;
      dx  <= 33'(rd_x) - 33'(xlo);
      dy  <= 33'(rd_y) - 33'(ylo);
      num_v <= 33'(r.query_x) - 33'(xlo);
    end
  end

  // operand magnitudes
  assign mag_num = $unsigned(num_v[32] ? -num_v : num_v);
  assign mag_dy  = $unsigned(dy[32] ? -dy : dy);

  // divider operands; one 33x33 multiply registered before launch
  always_ff @(posedge clk) begin
    div_start_q <= cmd.div_start;
    if (cmd.div_start) begin
      if (!cmd.div_sel) begin
        dividend <= 96'({33'd0, mag_num} * {33'd0, mag_dy});
        neg_v <= (num_v[32] ^ dy[32] ^ dx[32]) && num_v != '0 && dy != '0;
      end else begin
        dividend <= {63'd0, mag_dy} << FRAC_BITS;
        neg_s <= (dy[32] ^ dx[32]) && dy != '0;
      end
      ddx <= dx[32] ? -dx : dx;
    end
  end

  tli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start_q),
    .dividend (dividend),
    .divisor  (ddx),
    .done     (div_done),
    .quotient (quot)
  );

  assign q_signed = (cmd.div_sel ? neg_s : neg_v) ? -43'(quot) : 43'(quot);
  assign vsum = 44'(q_signed) + 44'(ylo);

  function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
    if (v > 44'sd2147483647) return 32'sh7fffffff;
    if (v < -44'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (div_done && !cmd.div_sel) val_q <= sat44(vsum);
    if (div_done && cmd.div_sel) slope_q <= sat44(44'(q_signed));
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= cmd.finish;
    if (cmd.finish) begin
      result.status <= cmd.fin_status;
      case (cmd.fin_status)
        ST_WRITE: begin
          result.value <= '0; result.slope <= '0; result.segment <= '0;
        end
        ST_CLAMP_LO: begin
          result.value <= rd_y; result.slope <= '0; result.segment <= '0;
        end
        ST_CLAMP_HI: begin
          result.value <= rd_y; result.slope <= '0;
          result.segment <= 5'(n_use - (AW+1)'(2));
        end
        ST_ZERO_SEG: begin
          result.value <= ylo; result.slope <= '0; result.segment <= 5'(lo);
        end
        default: begin
          result.value <= val_q; result.slope <= slope_q;
          result.segment <= 5'(lo);
        end
      endcase
    end
  end

  // the search never inverts its bounds
  assert property (@(posedge clk) disable iff (rst) cmd.step |=> lo < hi)
    else $error("search bounds crossed");
  // divider is never launched on two consecutive cycles
  assert property (@(posedge clk) disable iff (rst) div_start_q |=> !div_start_q)
    else $error("divider double start");
  // result slope is zero on every clamped outcome
  assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == ST_CLAMP_LO || result.status == ST_CLAMP_HI)
    |-> result.slope == '0)
    else $error("clamped result with slope");
endmodule
`default_nettype wire

### rtl/core/tli_control.sv
// Controller state machine sequencing table reads, search and division.
// Depends on tli_pkg.
`default_nettype none
module tli_control
  import tli_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     op,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (start) state_next = (op == OP_WRITE) ? S_DONE : S_RD_LO;
      S_RD_LO:    state_next = S_CHK_LO;
      S_CHK_LO:   state_next = stat.le_first ? S_DONE : S_CHK_HI;
      S_CHK_HI:   state_next = stat.ge_last ? S_DONE : S_SEARCH;
      S_SEARCH:   state_next = stat.search_done ? S_RD_SEG : S_SRCH_CHK;
      S_SRCH_CHK: state_next = S_SEARCH;
      S_RD_SEG:   state_next = S_PREP;
      S_PREP:     state_next = S_DIV_V;
      S_DIV_V:    if (stat.dx_zero) state_next = S_DONE;
                  else if (stat.div_done) state_next = S_DIV_S;
      S_DIV_S:    if (stat.div_done) state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  logic [1:0] outcome;  // 0 write, 1 lo, 2 hi, 3 other
  logic       divving;
  logic       zero_seen;
  always_ff @(posedge clk) begin
    if (rst) begin
      outcome <= '0; divving <= 1'b0; zero_seen <= 1'b0;
    end else begin
      if (state == S_IDLE && start) begin
        outcome <= 2'd0; zero_seen <= 1'b0;
      end
      if (state == S_CHK_LO) outcome <= stat.le_first ? 2'd1 : 2'd3;
      if (state == S_CHK_HI && stat.ge_last) outcome <= 2'd2;
      if (state == S_DIV_V && stat.dx_zero) zero_seen <= 1'b1;
      // set after the first cycle of a division state, so each launches once
      divving <= (state_next == state) && (state == S_DIV_V || state == S_DIV_S);
    end
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = state != S_IDLE;
    cmd.div_sel = (state == S_DIV_S);
    case (state)
      S_IDLE: begin
        cmd.capture = start;
        cmd.rd_first = 1'b1;
      end
      S_RD_LO:    cmd.rd_first = 1'b1;
      S_CHK_LO: begin
        cmd.rd_first = stat.le_first;  // keep y[0] for clamp
        cmd.rd_last = !stat.le_first;
      end
      S_CHK_HI:   cmd.rd_last = stat.ge_last;  // keep last y for clamp
      S_SEARCH: begin
        cmd.rd_mid = !stat.search_done;
        cmd.rd_lo = stat.search_done;
      end
      S_SRCH_CHK: cmd.step = 1'b1;
      S_RD_SEG:   cmd.rd_hi = 1'b1;
      S_PREP:     cmd.prep = 1'b1;
      S_DIV_V:    cmd.div_start = !divving && !stat.dx_zero;
      S_DIV_S:    cmd.div_start = !divving;
      S_DONE: begin
        cmd.finish = 1'b1;
        case (outcome)
          2'd0:    cmd.fin_status = ST_WRITE;
          2'd1:    cmd.fin_status = ST_CLAMP_LO;
          2'd2:    cmd.fin_status = ST_CLAMP_HI;
          default: cmd.fin_status = zero_seen ? ST_ZERO_SEG : ST_INTERP;
        endcase
        cmd.write_mem = (outcome == 2'd0);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
